// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types, sizes and helpers shared by the code bit packer modules.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	localparam int MAX_CODE_BITS = 32;
	localparam int SYMBOL_COUNT  = 256;
	localparam int BYTE_BITS     = 8;

	localparam int CODE_W = MAX_CODE_BITS;
	localparam int LEN_W  = $clog2(MAX_CODE_BITS + 1);
	localparam int SYM_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int ACC_W  = MAX_CODE_BITS + BYTE_BITS - 1;
	localparam int CNT_W  = $clog2(ACC_W + 1);
	localparam int SH_W   = $clog2(BYTE_BITS);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  symbol;
		logic [31:0] code_value;
		logic [5:0]  code_length;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} pack_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// Control of the item sitting in front of the packer.
	typedef struct packed {
		logic vld;
		op_t  op;
	} stage_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [5:0] len);
		if (len > 6'(MAX_CODE_BITS)) begin
			return LEN_W'(MAX_CODE_BITS);
		end
		return LEN_W'(len);
	endfunction

	// Clear code bits at and above the stored length.
	function automatic logic [CODE_W-1:0] mask_code(input logic [31:0] code,
		input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] full;
		logic [CODE_W-1:0] res;
		full = CODE_W'(code);
		for (int i = 0; i < CODE_W; i++) begin
			res[i] = full[i] & (LEN_W'(i) < len);
		end
		return res;
	endfunction

endpackage

// ----- rtl/hcbp_table.sv -----
// ----------------------------------------------------------------------------
// hcbp_table
// Code table memory: one write and one registered read per cycle, with a
// valid bit per entry so that unloaded entries read as length zero.
// ----------------------------------------------------------------------------
module hcbp_table
	import hcbp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [SYM_W-1:0] wr_idx,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic             rd_hit,
	input  logic [SYM_W-1:0] rd_idx,
	output entry_t           rd_data
);

	entry_t                  mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] vld_q;
	entry_t                  rd_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= rd_hit & vld_q[rd_idx];
			end
		end
	end

	// Unloaded or out-of-range entries read as empty codes; drop their stale bits.
	always_comb begin
		rd_data.code = rd_vld_q ? rd_q.code : '0;
		rd_data.len  = rd_vld_q ? rd_q.len : '0;
	end

endmodule

// ----- rtl/hcbp_packer.sv -----
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and output register: merges codes into the pending bits
// and sends one full byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcbp_packer
	import hcbp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  stage_t stage,
	input  entry_t entry,
	output logic   take,
	output logic   pack_valid,
	input  logic   pack_stall,
	output pack_t  pack
);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_vld_q;
	pack_t            out_q;

	logic             emit;
	logic [ACC_W-1:0] base_acc;
	logic [CNT_W-1:0] base_cnt;
	logic [ACC_W-1:0] acc_n;
	logic [CNT_W-1:0] cnt_n;

	always_comb begin
		emit     = (cnt_q >= CNT_W'(BYTE_BITS)) && (!out_vld_q || !pack_stall);
		base_acc = emit ? (acc_q >> BYTE_BITS) : acc_q;
		base_cnt = emit ? (cnt_q - CNT_W'(BYTE_BITS)) : cnt_q;
		// Take the next item once no full byte is left over.
		take     = stage.vld && (base_cnt < CNT_W'(BYTE_BITS));
		acc_n    = base_acc;
		cnt_n    = base_cnt;
		if (take) begin
			case (stage.op)
				OP_ENCODE: begin
					acc_n = base_acc | (ACC_W'(entry.code) << base_cnt[SH_W-1:0]);
					cnt_n = base_cnt + CNT_W'(entry.len);
				end
				OP_FLUSH: begin
					// Pad to a whole byte; upper bits are already zero.
					if (base_cnt != '0) begin
						cnt_n = CNT_W'(BYTE_BITS);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!pack_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte    <= acc_q[BYTE_BITS-1:0];
			out_q.last_of_run <= cnt_q < CNT_W'(2 * BYTE_BITS);
		end
	end

	assign pack_valid = out_vld_q;
	assign pack       = out_q;

	`ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(ACC_W), "accumulator count out of range")
	`ASSERT_ALWAYS(a_acc_clean, (acc_q >> cnt_q) == '0, "stale bits above accumulator count")
	`ASSERT_NEXT(a_flush_byte, take && (stage.op == OP_FLUSH) && (base_cnt != '0), cnt_q == CNT_W'(BYTE_BITS), "flush did not form a whole byte")

endmodule

// ----- rtl/huffman_code_bit_packer_unit.sv -----
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Code table lookup and bit packing of byte symbols into output bytes.
// ----------------------------------------------------------------------------
// An item is taken at most once per cycle. A load writes the 256-entry code
// table in the cycle it is taken; an encode reads the table into its read
// register as the item enters the stage register; the code is merged into
// the bit accumulator when the packer takes the item, and its bytes leave
// through the output register, one per cycle while the output is not
// stalled; the next item is merged in the cycle of the previous item's last
// byte. Loads, flushes, empty codes and short codes run at one item per cycle
// while the output is not stalled. The table needs no clearing after reset.
module huffman_code_bit_packer_unit
	import hcbp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  cmd_t  cmd,
	output logic  pack_valid,
	input  logic  pack_stall,
	output pack_t pack
);

	stage_t stage_s1;
	logic   take;
	logic   accept;
	logic   in_range;
	logic   is_load;
	logic   is_encode;
	logic   is_flush;
	entry_t wr_data;
	entry_t rd_data;

	assign cmd_stall = stage_s1.vld && !take;
	assign accept    = cmd_valid && !cmd_stall;
	assign in_range  = {1'b0, cmd.symbol} < 9'(SYMBOL_COUNT);
	assign is_load   = cmd.opcode == OP_LOAD;
	assign is_encode = cmd.opcode == OP_ENCODE;
	assign is_flush  = cmd.opcode == OP_FLUSH;

	always_comb begin
		wr_data.len  = sat_len(cmd.code_length);
		wr_data.code = mask_code(cmd.code_value, wr_data.len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1.vld <= 1'b0;
			stage_s1.op  <= OP_LOAD;
		end else if (accept) begin
			stage_s1.vld <= is_encode || is_flush;
			stage_s1.op  <= is_flush ? OP_FLUSH : OP_ENCODE;
		end else if (take) begin
			stage_s1.vld <= 1'b0;
		end
	end

	hcbp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load && in_range),
		.wr_idx  (cmd.symbol[SYM_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (accept && is_encode),
		.rd_hit  (in_range),
		.rd_idx  (cmd.symbol[SYM_W-1:0]),
		.rd_data (rd_data)
	);

	hcbp_packer u_packer (
		.clk        (clk),
		.arst_n     (arst_n),
		.stage      (stage_s1),
		.entry      (rd_data),
		.take       (take),
		.pack_valid (pack_valid),
		.pack_stall (pack_stall),
		.pack       (pack)
	);

endmodule
